// ----- rtl/smm_pkg.sv -----
// smm_pkg: types, character constants and small helper functions for the
// SIP method matcher. No dependencies; imported by smm_tail and the top level.
package smm_pkg;

    localparam int CIDX_W    = 5;    // character index width
    localparam int TEXT_W    = 128;  // method text, sixteen characters
    localparam int CFG_W     = 64;   // widest configuration register
    localparam int CFG_IDX_W = 2;
    localparam int FEED_N    = 3;    // replayed CR/LF bytes plus the current byte

    localparam logic [CIDX_W-1:0] LEN_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_HI = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_Q     = 8'h71;  // lower case q
    localparam logic [7:0] CASE_BIT = 8'h20;

    // "cse" as three folded bytes, oldest in the high byte
    localparam logic [23:0] CSEQ_PREFIX = 24'h637365;
    // "SIP/2.0 ", first character in the low byte
    localparam logic [63:0] REPLY_HEAD  = 64'h20302E322F504953;

    typedef enum logic [3:0] {
        PH_SKIP   = 4'd0,
        PH_HEAD   = 4'd1,
        PH_SEARCH = 4'd2,
        PH_COLON  = 4'd3,
        PH_LWS    = 4'd4,
        PH_TOKEN  = 4'd5,
        PH_SPACE  = 4'd6,
        PH_METHOD = 4'd7,
        PH_DONE   = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        V_MATCH   = 2'd0,
        V_NOMATCH = 2'd1,
        V_NOCSEQ  = 2'd2,
        V_PARSE   = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        REQ_FAIL  = 2'd0,
        REQ_PEND  = 2'd1,
        REQ_MATCH = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        LWS_NONE = 2'd0,
        LWS_LF   = 2'd1,
        LWS_CR   = 2'd2,
        LWS_CRLF = 2'd3
    } t_lws;

    // state carried through the token / space / method stages
    typedef struct packed {
        t_phase            phase;
        logic [CIDX_W-1:0] ci;
        logic              done;
        t_verdict          verdict;
    } t_tail;

    function automatic logic [7:0] fold(input logic [7:0] b);
        return (b inside {[8'h41:8'h5A]}) ? (b | CASE_BIT) : b;
    endfunction

    function automatic logic is_sp(input logic [7:0] b);
        return b inside {CH_SP, CH_TAB};
    endfunction

    function automatic logic is_brk(input logic [7:0] b);
        return b inside {CH_CR, CH_LF};
    endfunction

    // method character i; index sixteen and up reads as zero
    function automatic logic [7:0] mchar(input logic [TEXT_W-1:0] text,
                                         input logic [CIDX_W-1:0] i);
        return i[CIDX_W-1] ? 8'h00 : text[8*i[CIDX_W-2:0] +: 8];
    endfunction

    // first character: exact or lower-cased register byte; rest: case-folded
    function automatic logic char_ok(input logic [CIDX_W-1:0] i,
                                     input logic [7:0] b,
                                     input logic [7:0] m);
        if (i == '0) begin
            return (b == m) || (b == (m | CASE_BIT));
        end
        return fold(b) == fold(m);
    endfunction

endpackage

// ----- rtl/smm_tail.sv -----
// smm_tail: token, space and method stages of a reply, applied to up to three
// bytes in one pass (replayed CR/LF bytes, then the current byte). Uses smm_pkg.
module smm_tail
    import smm_pkg::*;
(
    input  t_tail                   i_st,
    input  logic [FEED_N-1:0]       i_feed_vld,
    input  logic [FEED_N-1:0][7:0]  i_feed_byte,
    input  logic [CIDX_W-1:0]       i_len,
    input  logic [TEXT_W-1:0]       i_text,
    output t_tail                   o_st
);

    always_comb begin
        t_tail      st;
        logic [7:0] b;
        logic       stop;
        st = i_st;
        for (int k = 0; k < FEED_N; k++) begin
            b    = i_feed_byte[k];
            stop = 1'b0;
            if (i_feed_vld[k] && !st.done) begin
                if (st.phase == PH_TOKEN) begin
                    if (is_sp(b) || is_brk(b)) begin
                        st.phase = PH_SPACE;
                    end else begin
                        stop = 1'b1;
                    end
                end
                if (!stop && st.phase == PH_SPACE) begin
                    if (is_sp(b)) begin
                        stop = 1'b1;
                    end else begin
                        st.phase = PH_METHOD;
                        st.ci    = '0;
                    end
                end
                if (!stop && st.phase == PH_METHOD) begin
                    if (st.ci < i_len) begin
                        if (!char_ok(st.ci, b, mchar(i_text, st.ci))) begin
                            st.done    = 1'b1;
                            st.verdict = V_NOMATCH;
                        end else begin
                            st.ci = st.ci + CIDX_W'(1);
                        end
                    end else begin
                        st.done    = 1'b1;
                        st.verdict = (b == CH_CR) ? V_MATCH : V_NOMATCH;
                    end
                end
            end
        end
        o_st = st;
    end

endmodule

// ----- rtl/sip_method_matcher.sv -----
// sip_method_matcher: classifies SIP messages by method, one byte per cycle unless stalled.
// Depends on smm_pkg and smm_tail.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one message byte per
//   request plus a last-byte flag. Output channel (o_out_valid / i_out_stall)
//   carries at most one verdict per message: 0 match, 1 no match,
//   2 reply without CSeq, 3 parse error.
//   Each byte is captured in an input register and classified by one pass of
//   logic once the output register is free; a verdict lands in that register.
//   One byte per cycle is taken while the receiver does not stall, as a single
//   pass of logic lies between the input and output registers.
//   When the receiver stalls, the verdict holds; the held byte waits and
//   o_in_stall rises only while both registers are full.
//   Bytes after a verdict are dropped until the last byte, which rearms
//   the matcher for the next message.
//   Configuration (method length, text) is written via i_cfg_we / i_cfg_index /
//   i_cfg_data, by the user between messages; the block does not enforce it.
//   Reset (synchronous, active low) empties both registers, rearms the
//   parser and loads a method length of six with empty text.
module sip_method_matcher
    import smm_pkg::*;
#(
    parameter int MAX_METHOD_CHARS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_msg_byte,
    input  logic                 i_last_byte,
    // verdict output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_verdict,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // longest method that is compared; the length register tops out at 31
    localparam logic [CIDX_W-1:0] MAX_LEN = (MAX_METHOD_CHARS > int'(LEN_MAX)) ?
                                            LEN_MAX : CIDX_W'(MAX_METHOD_CHARS);

    // configuration
    logic [CIDX_W-1:0]   r_method_length;
    logic [CFG_W-1:0]    r_text_low;
    logic [CFG_W-1:0]    r_text_high;
    logic [TEXT_W-1:0]   w_text;
    logic [CIDX_W-1:0]   w_len;

    // input and output registers
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    logic                r_out_valid;
    logic [1:0]          r_out_verdict;
    logic                w_out_free;
    logic                w_adv;

    // parser state
    t_phase              r_phase, n_phase;
    logic                r_is_reply, n_is_reply;
    logic [CIDX_W-1:0]   r_ci, n_ci;
    t_req                r_req, n_req;
    logic [23:0]         r_win, n_win;
    t_lws                r_lws, n_lws;

    // first-line test
    logic                h_init;
    logic [CIDX_W-1:0]   h_i;
    logic                h_rep_in;
    t_req                h_req_in;
    logic                h_rep;
    t_req                h_req;
    logic                h_to_search;
    logic                h_vld;
    t_verdict            h_verdict;

    // intermediate state after the byte, before the tail stages
    t_phase              m_phase;
    logic                m_rep;
    logic [CIDX_W-1:0]   m_ci;
    t_req                m_req;
    logic [23:0]         m_win;
    t_lws                m_lws;
    logic                hd_vld;
    t_verdict            hd_verdict;
    logic                feed_cur;
    logic                do_flush;
    t_lws                flush_p;
    logic [7:0]          b_fold;

    t_tail               t_in, t_out;
    logic [FEED_N-1:0]       feed_vld;
    logic [FEED_N-1:0][7:0]  feed_byte;

    logic                v_vld;
    t_verdict            v_code;

    assign w_text = {r_text_high, r_text_low};

    always_comb begin
        if (r_method_length == '0) begin
            w_len = CIDX_W'(1);
        end else if (r_method_length > MAX_LEN) begin
            w_len = MAX_LEN;
        end else begin
            w_len = r_method_length;
        end
    end

    // handshake: the held byte moves on whenever the output register can take it
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_adv       = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_out_verdict;

    assign b_fold = r_in_byte | CASE_BIT;

    // first line: reply head and request method tested side by side
    always_comb begin
        h_init   = (r_phase == PH_SKIP);
        h_i      = h_init ? '0 : r_ci;
        h_rep_in = h_init || r_is_reply;
        h_req_in = h_init ? REQ_PEND : r_req;
        h_rep    = h_rep_in && (h_i[CIDX_W-1:3] == '0) &&
                   (fold(r_in_byte) == fold(REPLY_HEAD[8*h_i[2:0] +: 8]));
        h_req    = h_req_in;
        if (h_req_in == REQ_PEND) begin
            if (h_i < w_len) begin
                h_req = char_ok(h_i, r_in_byte, mchar(w_text, h_i)) ? REQ_PEND : REQ_FAIL;
            end else begin
                h_req = (r_in_byte == CH_SP) ? REQ_MATCH : REQ_FAIL;
            end
        end
        // the reply reading wins when both complete on the eighth byte
        h_to_search = h_rep && (h_i == CIDX_W'(7));
        h_vld       = !h_rep && (h_req != REQ_PEND);
        h_verdict   = (h_req == REQ_MATCH) ? V_MATCH : V_NOMATCH;
    end

    // per-byte work up to the tail stages
    always_comb begin
        m_phase    = r_phase;
        m_rep      = r_is_reply;
        m_ci       = r_ci;
        m_req      = r_req;
        m_win      = r_win;
        m_lws      = r_lws;
        hd_vld     = 1'b0;
        hd_verdict = V_NOMATCH;
        feed_cur   = 1'b0;
        do_flush   = 1'b0;
        flush_p    = r_lws;
        case (r_phase)
            PH_SKIP, PH_HEAD: begin
                if (r_phase == PH_HEAD || !is_brk(r_in_byte)) begin
                    if (h_to_search) begin
                        m_phase = PH_SEARCH;
                        m_win   = '0;
                        m_rep   = 1'b1;
                    end else if (h_vld) begin
                        hd_vld     = 1'b1;
                        hd_verdict = h_verdict;
                    end else begin
                        m_phase = PH_HEAD;
                        m_ci    = h_i + CIDX_W'(1);
                        m_rep   = h_rep;
                        m_req   = h_req;
                    end
                end
            end
            PH_SEARCH: begin
                if (b_fold == CH_Q && r_win == CSEQ_PREFIX) begin
                    m_phase = PH_COLON;
                end
                m_win = {r_win[15:0], b_fold};
            end
            PH_COLON: begin
                if (r_in_byte == CH_COLON) begin
                    m_phase = PH_LWS;
                    m_lws   = LWS_NONE;
                end
            end
            PH_LWS: begin
                case (r_lws)
                    LWS_NONE: begin
                        if (r_in_byte == CH_LF) begin
                            m_lws = LWS_LF;
                        end else if (r_in_byte == CH_CR) begin
                            m_lws = LWS_CR;
                        end else if (!is_sp(r_in_byte)) begin
                            m_phase  = PH_TOKEN;
                            feed_cur = 1'b1;
                        end
                    end
                    LWS_LF, LWS_CRLF: begin
                        if (is_sp(r_in_byte)) begin
                            m_lws = LWS_NONE;
                        end else begin
                            // folded line did not continue: replay the break
                            m_phase  = PH_TOKEN;
                            m_lws    = LWS_NONE;
                            do_flush = 1'b1;
                            feed_cur = 1'b1;
                        end
                    end
                    default: begin
                        if (r_in_byte == CH_LF) begin
                            m_lws = LWS_CRLF;
                        end else begin
                            m_phase  = PH_TOKEN;
                            m_lws    = LWS_NONE;
                            do_flush = 1'b1;
                            feed_cur = 1'b1;
                        end
                    end
                endcase
            end
            PH_TOKEN, PH_SPACE, PH_METHOD: begin
                feed_cur = 1'b1;
            end
            default: begin
            end
        endcase
        // message ends inside whitespace: replay what is pending
        if (r_in_last && m_phase == PH_LWS) begin
            m_phase  = PH_TOKEN;
            do_flush = 1'b1;
            flush_p  = m_lws;
            m_lws    = LWS_NONE;
        end
    end

    always_comb begin
        t_in.phase   = m_phase;
        t_in.ci      = m_ci;
        t_in.done    = 1'b0;
        t_in.verdict = V_MATCH;
        feed_vld[0]  = do_flush && (flush_p != LWS_NONE);
        feed_byte[0] = (flush_p == LWS_LF) ? CH_LF : CH_CR;
        feed_vld[1]  = do_flush && (flush_p == LWS_CRLF);
        feed_byte[1] = CH_LF;
        feed_vld[2]  = feed_cur;
        feed_byte[2] = r_in_byte;
    end

    smm_tail u_tail (
        .i_st        (t_in),
        .i_feed_vld  (feed_vld),
        .i_feed_byte (feed_byte),
        .i_len       (w_len),
        .i_text      (w_text),
        .o_st        (t_out)
    );

    // verdict for this byte, including the end-of-message fallback
    always_comb begin
        v_vld  = hd_vld || t_out.done;
        v_code = hd_vld ? hd_verdict : t_out.verdict;
        if (!v_vld && r_in_last && r_phase != PH_DONE) begin
            v_vld = 1'b1;
            case (t_out.phase)
                PH_SEARCH:                   v_code = V_NOCSEQ;
                PH_COLON:                    v_code = V_PARSE;
                PH_SKIP, PH_HEAD, PH_METHOD: v_code = V_NOMATCH;
                default:                     v_code = V_PARSE;
            endcase
        end
    end

    // next parser state; the last byte always rearms
    always_comb begin
        n_phase    = v_vld ? PH_DONE : t_out.phase;
        n_ci       = t_out.ci;
        n_is_reply = m_rep;
        n_req      = m_req;
        n_win      = m_win;
        n_lws      = m_lws;
        if (r_in_last) begin
            n_phase    = PH_SKIP;
            n_ci       = '0;
            n_is_reply = 1'b0;
            n_req      = REQ_FAIL;
            n_win      = '0;
            n_lws      = LWS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_phase         <= PH_SKIP;
            r_ci            <= '0;
            r_is_reply      <= 1'b0;
            r_req           <= REQ_FAIL;
            r_win           <= '0;
            r_lws           <= LWS_NONE;
            r_method_length <= CIDX_W'(6);
            r_text_low      <= '0;
            r_text_high     <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv && v_vld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_phase    <= n_phase;
                r_ci       <= n_ci;
                r_is_reply <= n_is_reply;
                r_req      <= n_req;
                r_win      <= n_win;
                r_lws      <= n_lws;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LEN:     r_method_length <= i_cfg_data[CIDX_W-1:0];
                    CFG_TEXT_LO: r_text_low      <= i_cfg_data;
                    CFG_TEXT_HI: r_text_high     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_msg_byte;
            r_in_last <= i_last_byte;
        end
        if (w_adv && v_vld) begin
            r_out_verdict <= v_code;
        end
    end

`ifndef ASSERT_OFF
    // one verdict per message: nothing is issued once the parser has finished
    a_single_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_adv && v_vld && r_phase == PH_DONE))
        else $error("second verdict for one message");

    // a verdict mid-message parks the parser until the last byte
    a_done_after_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && v_vld && !r_in_last) |=> (r_phase == PH_DONE))
        else $error("parser not parked after verdict");

    // the last byte rearms the parser
    a_rearm_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_phase == PH_SKIP && r_lws == LWS_NONE))
        else $error("parser not rearmed after last byte");
`endif

endmodule

// ----- sim/tb_sip_method_matcher.sv -----
// tb_sip_method_matcher: self-checking bench for the SIP method matcher.
// Needs smm_pkg and sip_method_matcher; SIP messages are sent one byte per request
// and each verdict is checked against an in-bench model of the parser.
`timescale 1ns / 1ps

module tb_sip_method_matcher;
    import smm_pkg::*;

    localparam int ITEM_GOAL   = 1350;  // least number of bytes to send in total
    localparam int PHASE_BYTES = 80;    // least number of bytes per configuration setting
    localparam int NAME_MAX    = 16;    // method characters the block holds
    localparam int RESET_LEN   = 6;
    localparam int SETTLE      = 4;     // cycles after the last verdict

    // kinds of method text loaded into the block
    typedef enum int {TXT_UPPER, TXT_LOWER, TXT_ANY, TXT_ONES, TXT_ZERO} t_text_kind;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_req;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_msg_byte = 8'h00;
    logic                 i_last_byte = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_verdict;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LEN;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    sip_method_matcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_msg_byte  (i_msg_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_verdict   (o_verdict),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Parser model: configuration as the block sees it, plus parse state
    // ------------------------------------------------------------------
    logic [4:0]   cfg_len = 5'(RESET_LEN);
    logic [127:0] cfg_text = '0;

    t_phase      pr_phase = PH_SKIP;
    bit          pr_reply;       // still reading as a status line
    int          pr_idx;         // character position in the current line/method
    logic [23:0] pr_win;         // request status on line one, then cseq window
    t_lws        pr_lws = LWS_NONE;
    bit          pr_done;        // verdict already given for this message

    t_verdict    verdicts_due[$];
    bit          failed;

    function automatic logic [7:0] lower(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
    endfunction

    function automatic bit blank(input logic [7:0] b);
        return b == CH_SP || b == CH_TAB;
    endfunction

    // zero reads as one, anything past the text size is clipped
    function automatic int used_len();
        int n;
        n = cfg_len;
        if (n == 0) n = 1;
        if (n > NAME_MAX) n = NAME_MAX;
        return n;
    endfunction

    function automatic logic [7:0] method_byte(input int i);
        if (i < NAME_MAX) return cfg_text[8*i +: 8];
        return 8'h00;
    endfunction

    // first character may be the stored byte or that byte with bit 5 set;
    // later ones compare with letters folded to lower case
    function automatic bit name_char_ok(input int i, input logic [7:0] b);
        logic [7:0] m;
        m = method_byte(i);
        if (i == 0) return b == m || b == (m | 8'h20);
        return lower(b) == lower(m);
    endfunction

    function automatic void rearm_parser();
        pr_phase = PH_SKIP;
        pr_reply = 1'b0;
        pr_idx   = 0;
        pr_win   = '0;
        pr_lws   = LWS_NONE;
        pr_done  = 1'b0;
    endfunction

    // token, space and method stages of a reply; -1 while undecided
    function automatic int tail_verdict(input logic [7:0] b);
        int n;
        n = used_len();
        if (pr_phase == PH_TOKEN) begin
            if (!(blank(b) || b == CH_LF || b == CH_CR)) return -1;
            pr_phase = PH_SPACE;
        end
        if (pr_phase == PH_SPACE) begin
            if (blank(b)) return -1;
            pr_phase = PH_METHOD;
            pr_idx = 0;
        end
        if (pr_idx < n) begin
            if (!name_char_ok(pr_idx, b)) return V_NOMATCH;
            pr_idx++;
            return -1;
        end
        return (b == CH_CR) ? V_MATCH : V_NOMATCH;
    endfunction

    function automatic int feed_tail(input int v, input logic [7:0] b);
        return (v >= 0) ? v : tail_verdict(b);
    endfunction

    // a held line break that was not folded is handed on as plain bytes
    function automatic int replay_breaks();
        int   v;
        t_lws p;
        v = -1;
        p = pr_lws;
        pr_lws = LWS_NONE;
        pr_phase = PH_TOKEN;
        if (p == LWS_LF) v = feed_tail(v, CH_LF);
        if (p == LWS_CR || p == LWS_CRLF) v = feed_tail(v, CH_CR);
        if (p == LWS_CRLF) v = feed_tail(v, CH_LF);
        return v;
    endfunction

    // first line: status line test and request method test side by side
    function automatic int head_verdict(input logic [7:0] b);
        int i;
        int n;
        i = pr_idx;
        n = used_len();
        if (pr_reply && (i >= 8 || lower(b) != lower(REPLY_HEAD[8*(i%8) +: 8])))
            pr_reply = 1'b0;
        if (pr_win == REQ_PEND) begin
            if (i < n) begin
                if (!name_char_ok(i, b)) pr_win = REQ_FAIL;
            end else begin
                pr_win = (b == CH_SP) ? REQ_MATCH : REQ_FAIL;
            end
        end
        // the status line reading wins when both complete on byte eight
        if (pr_reply && i == 7) begin
            pr_phase = PH_SEARCH;
            pr_win = '0;
            return -1;
        end
        if (!pr_reply && pr_win != REQ_PEND)
            return (pr_win == REQ_MATCH) ? V_MATCH : V_NOMATCH;
        if (pr_idx < 63) pr_idx++;
        return -1;
    endfunction

    // whitespace after the colon, with folded line breaks
    function automatic int lws_verdict(input logic [7:0] b);
        int v;
        v = -1;
        case (pr_lws)
            LWS_NONE: begin
                if (b == CH_LF) begin
                    pr_lws = LWS_LF;
                end else if (b == CH_CR) begin
                    pr_lws = LWS_CR;
                end else if (!blank(b)) begin
                    pr_phase = PH_TOKEN;
                    v = tail_verdict(b);
                end
            end
            LWS_LF, LWS_CRLF: begin
                if (blank(b)) pr_lws = LWS_NONE;
                else v = feed_tail(replay_breaks(), b);
            end
            default: begin
                if (b == CH_LF) pr_lws = LWS_CRLF;
                else v = feed_tail(replay_breaks(), b);
            end
        endcase
        return v;
    endfunction

    // one byte in; returns the verdict it settles, or -1
    function automatic int classify_byte(input logic [7:0] b, input logic last);
        int v;
        v = -1;
        case (pr_phase)
            PH_SKIP: begin
                if (!(b == CH_CR || b == CH_LF)) begin
                    pr_phase = PH_HEAD;
                    pr_reply = 1'b1;
                    pr_idx   = 0;
                    pr_win   = REQ_PEND;
                    v = head_verdict(b);
                end
            end
            PH_HEAD: v = head_verdict(b);
            PH_SEARCH: begin
                if ((b | 8'h20) == CH_Q && pr_win == CSEQ_PREFIX) pr_phase = PH_COLON;
                pr_win = {pr_win[15:0], b | 8'h20};
            end
            PH_COLON: begin
                if (b == CH_COLON) begin
                    pr_phase = PH_LWS;
                    pr_lws = LWS_NONE;
                end
            end
            PH_LWS: v = lws_verdict(b);
            PH_TOKEN, PH_SPACE, PH_METHOD: v = tail_verdict(b);
            default: ;
        endcase

        // message ended before anything was decided
        if (v < 0 && last && !pr_done) begin
            if (pr_phase == PH_SEARCH) begin
                v = V_NOCSEQ;
            end else if (pr_phase == PH_COLON) begin
                v = V_PARSE;
            end else if (pr_phase inside {PH_SKIP, PH_HEAD, PH_METHOD}) begin
                v = V_NOMATCH;
            end else begin
                if (pr_phase == PH_LWS) v = replay_breaks();
                if (v < 0) v = (pr_phase == PH_METHOD) ? V_NOMATCH : V_PARSE;
            end
        end

        if (v >= 0) begin
            pr_phase = PH_DONE;
            pr_done = 1'b1;
        end
        if (last) rearm_parser();
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: tracks config writes, predicts on accepted bytes, checks
    // accepted verdicts. Runs at the rising edge; all stimulus moves on the
    // falling edge, so nothing here races with the drivers.
    // ------------------------------------------------------------------
    bit byte_taken;
    bit verdict_taken;

    always @(posedge i_clk) begin
        int       v;
        t_verdict want;
        byte_taken = 1'b0;
        verdict_taken = 1'b0;
        if (!i_rst_n) begin
            cfg_len  = 5'(RESET_LEN);
            cfg_text = '0;
            rearm_parser();
            verdicts_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LEN:     cfg_len = i_cfg_data[4:0];
                    CFG_TEXT_LO: cfg_text[63:0] = i_cfg_data;
                    CFG_TEXT_HI: cfg_text[127:64] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                byte_taken = 1'b1;
                v = classify_byte(i_msg_byte, i_last_byte);
                if (v >= 0) verdicts_due.push_back(t_verdict'(v));
            end
            if (o_out_valid && !i_out_stall) begin
                verdict_taken = 1'b1;
                if (verdicts_due.size() == 0) begin
                    $display("%0t: verdict expected none, got %0d", $time, o_verdict);
                    failed = 1'b1;
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_verdict !== want) begin
                        $display("%0t: verdict expected %0d, got %0d",
                                 $time, want, o_verdict);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte driver: pops pending requests; a random idle gap follows
    // each byte unless the current phase runs back to back.
    // ------------------------------------------------------------------
    t_byte_req byte_queue[$];
    bit        idle_on = 1'b1;
    int        send_gap;

    always @(negedge i_clk) begin
        t_byte_req item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !byte_taken)) begin
            // previous byte went in (or none was up): move on
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
                item = byte_queue.pop_front();
                i_msg_byte  <= item.data;
                i_last_byte <= item.last;
                i_in_valid  <= 1'b1;
                send_gap = idle_on ? $urandom_range(0, 5) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // verdict receiver: stalls for a random time after each accepted verdict unless the phase runs back to back
    int stall_left;

    always @(negedge i_clk) begin
        if (verdict_taken) stall_left = idle_on ? $urandom_range(0, 5) : 0;
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Message generation
    // ------------------------------------------------------------------
    logic [7:0] gen_chars[NAME_MAX];  // method text as loaded
    int         gen_len;              // characters the block compares
    logic [7:0] msg[$];               // message under construction
    int         bytes_queued;

    function automatic logic [7:0] random_case(input logic [7:0] b);
        if (lower(b) >= "a" && lower(b) <= "z" && $urandom_range(0, 1)) return b ^ 8'h20;
        return b;
    endfunction

    function automatic void add_text(input string s, input bit mix_case);
        for (int i = 0; i < s.len(); i++) msg.push_back(mix_case ? random_case(s[i]) : s[i]);
    endfunction

    function automatic void add_break();
        msg.push_back(CH_CR);
        msg.push_back(CH_LF);
    endfunction

    // method name that should match, with one character spoiled at times
    function automatic void add_method(input int spoil_pct);
        int         bad;
        logic [7:0] m;
        bad = ($urandom_range(0, 99) < spoil_pct) ? $urandom_range(0, gen_len - 1) : -1;
        for (int i = 0; i < gen_len; i++) begin
            m = gen_chars[i];
            if (i == bad) msg.push_back($urandom_range(0, 1) ? (m ^ 8'h20) : 8'($urandom));
            else if (i == 0) msg.push_back($urandom_range(0, 1) ? m : (m | 8'h20));
            else msg.push_back(random_case(m));
        end
    endfunction

    function automatic void add_leading_breaks(input int pct);
        if ($urandom_range(0, 99) < pct)
            repeat ($urandom_range(1, 3)) msg.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    endfunction

    // hand the message to the driver, flag its final byte, sometimes cut short
    function automatic void send_msg(input bit may_cut);
        int keep;
        t_byte_req item;
        if (may_cut && $urandom_range(0, 6) == 0) begin
            keep = $urandom_range(1, msg.size());
            while (msg.size() > keep) void'(msg.pop_back());
        end
        foreach (msg[i]) begin
            item.data = msg[i];
            item.last = (i == msg.size() - 1);
            byte_queue.push_back(item);
        end
        bytes_queued += msg.size();
        msg.delete();
    endfunction

    function automatic void build_request();
        add_leading_breaks(25);
        add_method(20);
        msg.push_back($urandom_range(0, 4) ? CH_SP : 8'($urandom));
        repeat ($urandom_range(0, 4)) msg.push_back(8'($urandom));
        send_msg(1'b1);
    endfunction

    function automatic void build_reply();
        add_leading_breaks(20);
        add_text("SIP/2.0 ", 1'b1);
        if ($urandom_range(0, 9) == 0) msg[msg.size() - $urandom_range(1, 8)] = 8'($urandom);
        case ($urandom_range(0, 3))
            0: add_text("200 OK", 1'b0);
            1: add_text("180 Ringing", 1'b0);
            2: add_text("Cse 3", 1'b1);   // partial decoy for the search
            default: ;
        endcase
        add_break();
        if ($urandom_range(0, 2) == 0) begin
            add_text("Call-ID: x", 1'b0);
            add_break();
        end
        add_text($urandom_range(0, 9) ? "CSeq" : "Cseg", 1'b1);
        if ($urandom_range(0, 3) == 0) msg.push_back(CH_SP);
        if ($urandom_range(0, 9)) msg.push_back(CH_COLON);
        // whitespace after the colon, folded or not
        case ($urandom_range(0, 7))
            0: ;
            1: msg.push_back(CH_SP);
            2: begin msg.push_back(CH_TAB); msg.push_back(CH_SP); end
            3: begin msg.push_back(CH_LF); msg.push_back(CH_SP); end
            4: begin add_break(); msg.push_back(CH_TAB); end
            5: add_break();            // not folded: breaks go on as token bytes
            6: msg.push_back(CH_LF);
            default: msg.push_back(CH_CR);
        endcase
        repeat ($urandom_range(1, 3)) msg.push_back(8'("0" + $urandom_range(0, 9)));
        repeat ($urandom_range(0, 2)) msg.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        add_method(15);
        msg.push_back($urandom_range(0, 4) ? CH_CR : 8'($urandom));
        msg.push_back(CH_LF);
        repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom));
        send_msg(1'b1);
    endfunction

    function automatic void build_noise();
        add_leading_breaks(30);
        repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
        send_msg(1'b0);
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
    endtask

    // load method length and text; fixed text wins over the random kind
    task automatic set_method(input int len_reg, input string fixed, input t_text_kind kind);
        logic [CFG_W-1:0] len_word;
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        for (int i = 0; i < NAME_MAX; i++) begin
            if (fixed.len() != 0) gen_chars[i] = (i < fixed.len()) ? fixed[i] : 8'h00;
            else case (kind)
                TXT_UPPER: gen_chars[i] = 8'("A" + $urandom_range(0, 25));
                TXT_LOWER: gen_chars[i] = 8'("a" + $urandom_range(0, 25));
                TXT_ANY:   gen_chars[i] = 8'($urandom);
                TXT_ONES:  gen_chars[i] = 8'hFF;
                default:   gen_chars[i] = 8'h00;
            endcase
        end
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = gen_chars[i];
            hi[8*i +: 8] = gen_chars[i + 8];
        end
        gen_len = (len_reg == 0) ? 1 : (len_reg > NAME_MAX) ? NAME_MAX : len_reg;
        // upper bits of the length word are don't-care; toggle them anyway
        len_word = {$urandom, $urandom};
        len_word[4:0] = 5'(len_reg);
        write_reg(CFG_LEN, len_word);
        write_reg(CFG_TEXT_LO, lo);
        write_reg(CFG_TEXT_HI, hi);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // all bytes in, all verdicts out, then a settling wait of SETTLE for trailing bytes
    task automatic wait_idle();
        do @(posedge i_clk);
        while (byte_queue.size() != 0 || i_in_valid || verdicts_due.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int phase_start;
        int pick;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short method, case rules, line-break-only and cut messages
        set_method(3, "ACK", TXT_UPPER);
        add_text("ACK ", 1'b0);                 send_msg(1'b0);   // match
        msg.push_back(CH_LF);
        add_text("acK ", 1'b0);                 send_msg(1'b0);   // lower first char ok
        add_text("ACKS", 1'b0);                 send_msg(1'b0);   // no space after name
        add_break();                            send_msg(1'b0);   // only line breaks
        msg.push_back(8'hFF);                   send_msg(1'b0);
        msg.push_back(8'h00); msg.push_back(8'h80); send_msg(1'b0); // ignored after verdict
        add_text("SIP/2", 1'b0);                send_msg(1'b0);   // first line unfinished

        for (int ph = 1; bytes_queued < ITEM_GOAL; ph++) begin
            wait_idle();
            idle_on = (ph % 3 != 2);
            case (ph)
                1: set_method(16, "", TXT_UPPER);
                2: set_method(1, "", TXT_UPPER);
                3: set_method(0, "", TXT_UPPER);                 // zero acts as one
                4: set_method(31, "", TXT_UPPER);                // clipped to sixteen
                5: set_method($urandom_range(17, 30), "", TXT_UPPER);
                6: set_method(7, "SIP/2.0", TXT_UPPER);          // request looks like a reply
                7: set_method($urandom_range(1, 16), "", TXT_ONES);
                8: set_method($urandom_range(1, 4), "", TXT_ZERO); // NUL bytes in the name
                9: set_method($urandom_range(1, 16), "", TXT_LOWER);
                default: begin
                    pick = $urandom_range(0, 3);
                    if (pick == 0) set_method($urandom_range(1, 16), "", TXT_ANY);
                    else if (pick == 1) set_method($urandom_range(3, 6), "", TXT_UPPER);
                    else set_method($urandom_range(1, 16), "", TXT_UPPER);
                end
            endcase
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) build_request();
                else if (pick < 80) build_reply();
                else build_noise();
            end
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (!failed) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
